FILE: rtl/core/binary_gcd_defines.svh
`ifndef BINARY_GCD_DEFINES_SVH
`define BINARY_GCD_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BGCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bgcd_pkg.sv
`default_nettype none

package bgcd_pkg;

	localparam int FIELD_W   = 32;
	localparam int WIDTH_DEF = 32;

	// Per-cycle command broadcast to every cell of the row.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_HALVE_BOTH,
		OP_HALVE_X,
		OP_HALVE_Y,
		OP_SUB_X,
		OP_SUB_Y
	} cell_op_t;

	// Bits handed from a cell down to its lower neighbor.
	typedef struct packed {
		logic x;
		logic y;
		logic dxy;
		logic dyx;
	} link_t;

	// Borrow chain, rippling from the low cell upward.
	typedef struct packed {
		logic bxy;
		logic byx;
	} borrow_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STRIP,
		ST_REDUCE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/binary_gcd.sv
// Binary GCD, one result beat per operand beat, one item in flight.
// Each item is loaded, stripped of shared factors of two, then reduced by halve/subtract
// steps until both lanes match (no reduction when they already match once stripped).
// Output register lets the next item start while a result waits.
// Reset: arst_n clears control state at once; no clearing pass is needed.
`default_nettype none

`include "binary_gcd_defines.svh"

module binary_gcd #(
	parameter int WIDTH = bgcd_pkg::WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bgcd_pkg::FIELD_W-1:0]  operand_a,
	input  wire logic [bgcd_pkg::FIELD_W-1:0]  operand_b,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bgcd_pkg::FIELD_W-1:0]       divisor
);

	logic [WIDTH-1:0]   a_w;
	logic [WIDTH-1:0]   b_w;
	logic [WIDTH-1:0]   ld_a;
	logic [WIDTH-1:0]   ld_b;
	logic               zero_pair;
	logic [WIDTH-1:0]   x_vec;
	logic [WIDTH-1:0]   y_vec;
	bgcd_pkg::cell_op_t op;

	// Cell i reads link[i+1] from its upper neighbor; top sees zeros.
	bgcd_pkg::link_t    link [WIDTH:0];
	// Borrow enters cell 0 at zero and leaves the top cell.
	bgcd_pkg::borrow_t  brw  [WIDTH:0];

	assign a_w = WIDTH'(operand_a);
	assign b_w = WIDTH'(operand_b);

	// With a zero operand, load the other into both lanes: the row then
	// starts equal and the result falls out with no steps at all.
	assign zero_pair = (a_w == '0) || (b_w == '0);
	assign ld_a      = zero_pair ? (a_w | b_w) : a_w;
	assign ld_b      = zero_pair ? (a_w | b_w) : b_w;

	assign link[WIDTH] = '0;
	assign brw[0]      = '0;

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		bgcd_cell u_cell (
			.clk  (clk),
			.op   (op),
			.ld_x (ld_a[i]),
			.ld_y (ld_b[i]),
			.up   (link[i+1]),
			.dn   (link[i]),
			.bin  (brw[i]),
			.bout (brw[i+1]),
			.x    (x_vec[i]),
			.y    (y_vec[i])
		);
	end

	// Sequence strip, reduce and output; borrow out of x - y marks x < y.
	bgcd_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_vec     (x_vec),
		.y_vec     (y_vec),
		.x_lt_y    (brw[WIDTH].bxy),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.divisor   (divisor)
	);

	// Accepting a beat makes the block busy.
	`BGCD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"block took an input beat but did not go busy")

	// While working, the x lane is never zero unless the y lane is too.
	`BGCD_ASSERT_NOW(a_no_lone_zero, in_stall && (x_vec == '0), y_vec == '0,
		"a single lane reached zero during the reduction")

	// Going idle always leaves a result in the output register.
	`BGCD_ASSERT_NOW(a_result_on_idle, $fell(in_stall), out_valid,
		"returned to idle without presenting a result")

endmodule

`default_nettype wire

FILE: rtl/core/bgcd_cell.sv
`default_nettype none

module bgcd_cell (
	input  wire logic               clk,
	input  wire bgcd_pkg::cell_op_t op,
	input  wire logic               ld_x,
	input  wire logic               ld_y,
	input  wire bgcd_pkg::link_t    up,
	output bgcd_pkg::link_t         dn,
	input  wire bgcd_pkg::borrow_t  bin,
	output bgcd_pkg::borrow_t       bout,
	output logic                    x,
	output logic                    y
);

	logic x_q;
	logic y_q;

	// One bit of x - y and of y - x.
	always_comb begin
		dn.x      = x_q;
		dn.y      = y_q;
		dn.dxy    = x_q ^ y_q ^ bin.bxy;
		dn.dyx    = x_q ^ y_q ^ bin.byx;
		bout.bxy  = (~x_q & y_q) | (~(x_q ^ y_q) & bin.bxy);
		bout.byx  = (~y_q & x_q) | (~(x_q ^ y_q) & bin.byx);
	end

	// Load, or take the upper neighbor's bit (plain to halve, difference to subtract).
	always_ff @(posedge clk) begin
		case (op)
			bgcd_pkg::OP_LOAD: begin
				x_q <= ld_x;
				y_q <= ld_y;
			end
			bgcd_pkg::OP_HALVE_BOTH: begin
				x_q <= up.x;
				y_q <= up.y;
			end
			bgcd_pkg::OP_HALVE_X: x_q <= up.x;
			bgcd_pkg::OP_HALVE_Y: y_q <= up.y;
			bgcd_pkg::OP_SUB_X:   x_q <= up.dxy;
			bgcd_pkg::OP_SUB_Y:   y_q <= up.dyx;
			default: begin
				x_q <= x_q;
				y_q <= y_q;
			end
		endcase
	end

	assign x = x_q;
	assign y = y_q;

endmodule

`default_nettype wire

FILE: rtl/core/bgcd_ctrl.sv
`default_nettype none

module bgcd_ctrl #(
	parameter int WIDTH = bgcd_pkg::WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [WIDTH-1:0]              x_vec,
	input  wire logic [WIDTH-1:0]              y_vec,
	input  wire logic                          x_lt_y,
	output bgcd_pkg::cell_op_t                 op,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bgcd_pkg::FIELD_W-1:0]       divisor
);

	localparam int CNT_W = $clog2(WIDTH);

	bgcd_pkg::state_t state_q;
	bgcd_pkg::state_t state_nxt;

	logic [CNT_W-1:0]             shared_q;
	logic                         out_valid_q;
	logic [bgcd_pkg::FIELD_W-1:0] divisor_q;
	logic                         eq;
	logic                         out_free;
	logic                         finish;

	assign eq       = (x_vec == y_vec);
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == bgcd_pkg::ST_DONE) && out_free;

	always_comb begin
		case (state_q)
			bgcd_pkg::ST_IDLE:
				state_nxt = in_valid ? bgcd_pkg::ST_STRIP : bgcd_pkg::ST_IDLE;
			bgcd_pkg::ST_STRIP: begin
				if (eq)
					state_nxt = bgcd_pkg::ST_DONE;
				else if (!x_vec[0] && !y_vec[0])
					state_nxt = bgcd_pkg::ST_STRIP;
				else
					state_nxt = bgcd_pkg::ST_REDUCE;
			end
			bgcd_pkg::ST_REDUCE:
				state_nxt = eq ? bgcd_pkg::ST_DONE : bgcd_pkg::ST_REDUCE;
			bgcd_pkg::ST_DONE:
				state_nxt = out_free ? bgcd_pkg::ST_IDLE : bgcd_pkg::ST_DONE;
			default:
				state_nxt = bgcd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		op       = bgcd_pkg::OP_HOLD;
		in_stall = (state_q != bgcd_pkg::ST_IDLE);
		case (state_q)
			bgcd_pkg::ST_IDLE:
				if (in_valid)
					op = bgcd_pkg::OP_LOAD;
			bgcd_pkg::ST_STRIP:
				if (!eq && !x_vec[0] && !y_vec[0])
					op = bgcd_pkg::OP_HALVE_BOTH;
			bgcd_pkg::ST_REDUCE: begin
				if (eq)
					op = bgcd_pkg::OP_HOLD;
				else if (!x_vec[0])
					op = bgcd_pkg::OP_HALVE_X;
				else if (!y_vec[0])
					op = bgcd_pkg::OP_HALVE_Y;
				else if (!x_lt_y)
					op = bgcd_pkg::OP_SUB_X;
				else
					op = bgcd_pkg::OP_SUB_Y;
			end
			default:
				op = bgcd_pkg::OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bgcd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Count shared factors of two; restore them on the way out.
	always_ff @(posedge clk) begin
		if (op == bgcd_pkg::OP_LOAD)
			shared_q <= '0;
		else if (op == bgcd_pkg::OP_HALVE_BOTH)
			shared_q <= shared_q + CNT_W'(1);
		if (finish)
			divisor_q <= bgcd_pkg::FIELD_W'(x_vec << shared_q);
	end

	assign out_valid = out_valid_q;
	assign divisor   = divisor_q;

endmodule

`default_nettype wire
